>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/zfe_pkg.sv
// ----------------------------------------------------------------------------
// z function engine package
// field widths, controller states and controller/datapath handshake types
// ----------------------------------------------------------------------------
package zfe_pkg;

    localparam int CFG_W       = 12;
    localparam int CHAR_W      = 8;
    localparam int IDX_W       = 12;
    localparam int ZV_W        = 13;
    localparam int MAX_LEN_DEF = 4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ZRD,
        ST_ZINIT,
        ST_CHK,
        ST_CMP,
        ST_WR,
        ST_RD
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_req;
        logic start;
        logic zrd;
        logic zinit;
        logic chk_rd;
        logic inc;
        logic wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic start_go;
        logic ext_ok;
        logic char_eq;
        logic more;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/zfe_in_if.sv
// ----------------------------------------------------------------------------
// z function engine input channel
// valid/ready channel carrying one load or read transaction
// ----------------------------------------------------------------------------
interface zfe_in_if
    import zfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAR_W-1:0] char_in;
    logic              is_last;
    logic [IDX_W-1:0]  index;

    modport source (output valid, output func, output char_in, output is_last,
                    output index, input ready);
    modport sink   (input valid, input func, input char_in, input is_last,
                    input index, output ready);
endinterface

>>> rtl/core/zfe_out_if.sv
// ----------------------------------------------------------------------------
// z function engine output channel
// valid/ready channel carrying one read result transaction
// ----------------------------------------------------------------------------
interface zfe_out_if
    import zfe_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [ZV_W-1:0] z_value;
    logic            in_range;

    modport source (output valid, output z_value, output in_range, input ready);
    modport sink   (input valid, input z_value, input in_range, output ready);
endinterface

>>> rtl/core/z_function_engine_unit.sv
// ----------------------------------------------------------------------------
// z function engine
// Z-array of a loaded byte string window, read back one entry per transaction
// ----------------------------------------------------------------------------
// usage
//   i_in carries load transactions (func 0, char_in, is_last) and read
//   transactions (func 1, index). a load with is_last ends the string and
//   starts the z pass over the window from start_offset to the end.
//   i_cfg_wr_en / i_cfg_wr_data write start_offset, sampled when the z pass
//   starts. o_out returns one transaction per read: z_value and in_range.
// sequencing
//   a load is taken in the idle state. a read registers its z entry and hit
//   flag, the result register is loaded once o_out is free, and the next
//   transaction is taken after that. the z pass runs on one char memory
//   port pair with registered reads: per window position it reads the z
//   entry, sets the initial match length, then checks and compares while
//   characters match and writes the entry on a mismatch or at the window
//   end, at most one mismatch per position and about one match per position
//   overall. i_in.ready is low for the whole z pass and for a pending read.
// reset and stall
//   reset clears the string, the window and start_offset; memories are not
//   cleared. a stalled o_out holds its result; loads are still taken, and a
//   following read waits in the engine until the result register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module z_function_engine_unit
    import zfe_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    zfe_in_if.sink           i_in,
    zfe_out_if.source        o_out
);

    t_cmd    s_cmd;
    t_status s_status;
    logic    in_ready;

    zfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_in_last  (i_in.is_last),
        .i_status   (s_status),
        .o_in_ready (in_ready),
        .o_cmd      (s_cmd)
    );

    zfe_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char_in     (i_in.char_in),
        .i_index       (i_in.index),
        .i_cmd         (s_cmd),
        .o_status      (s_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_z_value     (o_out.z_value),
        .o_in_range    (o_out.in_range)
    );

    assign i_in.ready = in_ready;

    `ASSERT_NEXT(a_read_blocks_input, i_clk, i_rst_n,
        i_in.valid && i_in.ready && i_in.func, !i_in.ready, "input taken behind a read")
    `ASSERT_NEXT(a_last_starts_pass, i_clk, i_rst_n,
        i_in.valid && i_in.ready && !i_in.func && i_in.is_last, !i_in.ready,
        "input taken while z pass starts")
    `ASSERT_IMPL(a_no_result_overwrite, i_clk, i_rst_n,
        s_cmd.out_load, !o_out.valid || o_out.ready, "result register overwritten")
    `ASSERT_IMPL(a_miss_is_zero, i_clk, i_rst_n,
        o_out.valid && !o_out.in_range, o_out.z_value == '0, "out of range read not zero")

endmodule

>>> rtl/core/zfe_ctrl.sv
// ----------------------------------------------------------------------------
// z function engine controller
// sequences loads, reads and the z box pass over the datapath
// ----------------------------------------------------------------------------
module zfe_ctrl
    import zfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_func,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_func) begin
                        n_state = ST_RD;
                    end else if (i_in_last) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_state = i_status.start_go ? ST_ZRD : ST_IDLE;
            end
            ST_ZRD: begin
                n_state = ST_ZINIT;
            end
            ST_ZINIT: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = i_status.ext_ok ? ST_CMP : ST_WR;
            end
            ST_CMP: begin
                n_state = i_status.char_eq ? ST_CHK : ST_WR;
            end
            ST_WR: begin
                n_state = i_status.more ? ST_ZRD : ST_IDLE;
            end
            ST_RD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load   = i_in_valid && !i_in_func;
                o_cmd.rd_req = i_in_valid && i_in_func;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
            end
            ST_ZRD: begin
                o_cmd.zrd = 1'b1;
            end
            ST_ZINIT: begin
                o_cmd.zinit = 1'b1;
            end
            ST_CHK: begin
                o_cmd.chk_rd = i_status.ext_ok;
            end
            ST_CMP: begin
                o_cmd.inc = i_status.char_eq;
            end
            ST_WR: begin
                o_cmd.wr = 1'b1;
            end
            ST_RD: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/zfe_datapath.sv
// ----------------------------------------------------------------------------
// z function engine datapath
// character and z memories, box registers, offset register and result register
// ----------------------------------------------------------------------------
module zfe_datapath
    import zfe_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic [IDX_W-1:0]  i_index,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ZV_W-1:0]   o_z_value,
    output logic              o_in_range
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int ZW = (CW > ZV_W) ? CW : ZV_W;

    logic [CHAR_W-1:0] char_mem [MAX_LEN];
    logic [CW-1:0]     z_mem    [MAX_LEN];

    logic [CFG_W-1:0]  r_offset;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_wlen;
    logic              r_done;
    logic              r_out_valid;

    logic [AW-1:0]     r_base;
    logic [CW-1:0]     r_n;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_l;
    logic [CW-1:0]     r_rend;
    logic [CW-1:0]     r_zi;
    logic [CHAR_W-1:0] r_ca;
    logic [CHAR_W-1:0] r_cb;
    logic [CW-1:0]     r_zq;
    logic              r_hit;
    logic [ZV_W-1:0]   r_z_value;
    logic              r_in_range;

    logic [CW-1:0]     cnt_eff;
    logic              room;
    logic [XW-1:0]     off_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     wlen_x;
    logic [XW-1:0]     n_diff;
    logic [CW-1:0]     n_calc;
    logic              go0;
    logic              hit;
    logic [CW-1:0]     ext;
    logic [CW-1:0]     sum_a;
    logic [CW-1:0]     sum_b;
    logic [CW-1:0]     i_minus_l;
    logic [AW-1:0]     z_rd_addr;
    logic [CW-1:0]     box_rem;
    logic [CW-1:0]     zi_init;
    logic [ZW-1:0]     zq_x;

    // load and window bookkeeping
    assign cnt_eff = r_done ? '0 : r_count;
    assign room    = cnt_eff < CW'(MAX_LEN);
    assign off_x   = XW'(r_offset);
    assign cnt_x   = XW'(r_count);
    assign idx_x   = XW'(i_index);
    assign wlen_x  = XW'(r_wlen);
    assign go0     = off_x < cnt_x;
    assign n_diff  = cnt_x - off_x;
    assign n_calc  = n_diff[CW-1:0];
    assign hit     = r_done && (idx_x < wlen_x);

    // box pass arithmetic
    assign ext       = r_i + r_zi;
    assign sum_a     = CW'(r_base) + r_zi;
    assign sum_b     = sum_a + r_i;
    assign i_minus_l = r_i - r_l;
    assign z_rd_addr = i_cmd.rd_req ? idx_x[AW-1:0] : i_minus_l[AW-1:0];
    assign box_rem   = r_rend - r_i;
    assign zi_init   = (r_i < r_rend) ? ((box_rem < r_zq) ? box_rem : r_zq) : '0;
    assign zq_x      = ZW'(r_zq);

    assign o_status.start_go = go0 && (n_calc > CW'(1));
    assign o_status.ext_ok   = ext < r_n;
    assign o_status.char_eq  = r_ca == r_cb;
    assign o_status.more     = (r_i + CW'(1)) < r_n;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_count     <= '0;
            r_wlen      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_count <= room ? (cnt_eff + CW'(1)) : cnt_eff;
                if (r_done) begin
                    r_wlen <= '0;
                    r_done <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_done <= 1'b1;
                r_wlen <= go0 ? n_calc : '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // box registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_base <= off_x[AW-1:0];
            r_n    <= n_calc;
            r_i    <= CW'(1);
            r_l    <= '0;
            r_rend <= '0;
        end
        if (i_cmd.zinit) begin
            r_zi <= zi_init;
        end
        if (i_cmd.inc) begin
            r_zi <= r_zi + CW'(1);
        end
        if (i_cmd.wr) begin
            if (ext > r_rend) begin
                r_l    <= r_i;
                r_rend <= ext;
            end
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.rd_req) begin
            r_hit <= hit;
        end
        if (i_cmd.out_load) begin
            r_z_value  <= r_hit ? zq_x[ZV_W-1:0] : '0;
            r_in_range <= r_hit;
        end
    end

    // character memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            char_mem[cnt_eff[AW-1:0]] <= i_char_in;
        end
        if (i_cmd.chk_rd) begin
            r_ca <= char_mem[sum_a[AW-1:0]];
            r_cb <= char_mem[sum_b[AW-1:0]];
        end
    end

    // z memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            z_mem[AW'(0)] <= n_calc;
        end else if (i_cmd.wr) begin
            z_mem[r_i[AW-1:0]] <= r_zi;
        end
        if (i_cmd.zrd || i_cmd.rd_req) begin
            r_zq <= z_mem[z_rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_z_value   = r_z_value;
    assign o_in_range  = r_in_range;

endmodule
